@@ rtl/adsr_pkg.sv @@
// Shared types, widths and register map of the ADSR envelope generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package adsr_pkg;

   localparam int LEVEL_BITS   = 16;
   localparam int TICK_BITS    = 24;
   localparam int ELAPSED_BITS = TICK_BITS + 1;
   localparam int PROD_BITS    = LEVEL_BITS + TICK_BITS;
   localparam int DIV_STEPS    = LEVEL_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
   localparam int DATA_BITS    = 32;
   localparam int ADDR_BITS    = 5;
   localparam int INDEX_BITS   = 3;

   localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

   // register indexes (byte address = 4 * index)
   localparam logic [INDEX_BITS-1:0] REG_START_LEVEL   = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_PEAK_LEVEL    = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_ATTACK_TICKS  = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_DECAY_TICKS   = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_RELEASE_TICKS = 3'd5;

   localparam logic [LEVEL_BITS-1:0] RST_START_LEVEL   = 16'd0;
   localparam logic [LEVEL_BITS-1:0] RST_PEAK_LEVEL    = 16'd65535;
   localparam logic [LEVEL_BITS-1:0] RST_SUSTAIN_LEVEL = 16'd32768;
   localparam logic [TICK_BITS-1:0]  RST_ATTACK_TICKS  = 24'd480;
   localparam logic [TICK_BITS-1:0]  RST_DECAY_TICKS   = 24'd480;
   localparam logic [TICK_BITS-1:0]  RST_RELEASE_TICKS = 24'd480;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } adsr_phase_type;

   typedef enum logic [2:0] {
      S_WAIT,
      S_CHECK,
      S_MUL,
      S_DIV,
      S_DONE
   } adsr_state_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] start_level;
      logic [LEVEL_BITS-1:0] peak_level;
      logic [LEVEL_BITS-1:0] sustain_level;
      logic [TICK_BITS-1:0]  attack_ticks;
      logic [TICK_BITS-1:0]  decay_ticks;
      logic [TICK_BITS-1:0]  release_ticks;
   } adsr_cfg_type;

   typedef struct packed {
      logic accept;    // apply gate edge of the new request
      logic advance;   // current ramp is over: go to the next phase
      logic load;      // latch ramp operands
      logic mul;       // form product and seed the divider
      logic div_step;  // one restoring division step
      logic commit;    // finish the tick and load the result register
   } adsr_cmd_type;

   typedef struct packed {
      logic ramping;   // phase is attack, decay or release
      logic at_end;    // elapsed ticks reached the phase length
   } adsr_status_type;

endpackage

@@ rtl/adsr_envelope_generator.sv @@
// Top level of the linear ADSR envelope generator: register file, sequencer
// and datapath. Depends on adsr_pkg, adsr_csr, adsr_ctrl and adsr_dp.
`timescale 1ns / 1ps

// Each request is one sample tick carrying the key gate; each request yields
// exactly one response with the envelope level and phase for that tick. A
// ramp request first applies the gate edge in the cycle in which it is
// accepted; the check state then settles the phase (a finished attack moves
// into the decay in the same tick), the multiply state forms the 16x24
// product of ramp span and elapsed ticks, the radix-2 restoring divider
// divides it by the ramp length (one quotient bit per cycle), and the commit
// state loads the response register. The divider sets the rate; idle and
// sustain ticks skip it and go from the check state straight to commit. A
// stalled response holds the next finished request in its commit cycle until
// the response register frees. One request is in flight at a time, and the
// response register lets the next request in while a response still waits.
// Registers sit at byte addresses 4*i: start_level, peak_level,
// sustain_level, attack_ticks, decay_ticks, release_ticks; write them only
// while no request is pending.

module adsr_envelope_generator (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_gate,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [adsr_pkg::LEVEL_BITS-1:0] rsp_level,
   output logic [2:0]                     rsp_phase,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [adsr_pkg::ADDR_BITS-1:0] paddr,
   input  logic [adsr_pkg::DATA_BITS-1:0] pwdata,
   output logic [adsr_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);
   import adsr_pkg::*;

   adsr_cfg_type     cfg;
   adsr_cmd_type     cmd;
   adsr_status_type  status;

   // configuration registers, read back zero-extended from their field widths
   adsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: accept, settle phase, multiply, divide, commit
   adsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // envelope state and arithmetic
   adsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_gate  (req_gate),
      .status    (status),
      .rsp_level (rsp_level),
      .rsp_phase (rsp_phase)
   );

   // an accepted request stalls the request channel in the cycle after its acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // an idle response always carries level zero
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase == PH_IDLE) |-> (rsp_level == '0))
      else $error("idle response with nonzero level");

   // a sustain response carries the programmed sustain level
   a_sustain_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase == PH_SUSTAIN) |-> (rsp_level == cfg.sustain_level))
      else $error("sustain response differs from sustain level");

   // commit never overwrites a response that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

endmodule

@@ rtl/adsr_csr.sv @@
// Configuration register file of the ADSR envelope generator (APB-style).
// Depends on adsr_pkg.
`timescale 1ns / 1ps

module adsr_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [adsr_pkg::ADDR_BITS-1:0] paddr,
   input  logic [adsr_pkg::DATA_BITS-1:0] pwdata,
   output logic [adsr_pkg::DATA_BITS-1:0] prdata,
   output logic                         pready,
   output adsr_pkg::adsr_cfg_type       cfg
);
   import adsr_pkg::*;

   adsr_cfg_type           cfg_ff, cfg_in;
   logic [INDEX_BITS-1:0]  index;
   logic                   wr_en;

   assign index  = paddr[ADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_START_LEVEL:   cfg_in.start_level   = pwdata[LEVEL_BITS-1:0];
            REG_PEAK_LEVEL:    cfg_in.peak_level    = pwdata[LEVEL_BITS-1:0];
            REG_SUSTAIN_LEVEL: cfg_in.sustain_level = pwdata[LEVEL_BITS-1:0];
            REG_ATTACK_TICKS:  cfg_in.attack_ticks  = pwdata[TICK_BITS-1:0];
            REG_DECAY_TICKS:   cfg_in.decay_ticks   = pwdata[TICK_BITS-1:0];
            REG_RELEASE_TICKS: cfg_in.release_ticks = pwdata[TICK_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_START_LEVEL:   prdata = DATA_BITS'(cfg_ff.start_level);
         REG_PEAK_LEVEL:    prdata = DATA_BITS'(cfg_ff.peak_level);
         REG_SUSTAIN_LEVEL: prdata = DATA_BITS'(cfg_ff.sustain_level);
         REG_ATTACK_TICKS:  prdata = DATA_BITS'(cfg_ff.attack_ticks);
         REG_DECAY_TICKS:   prdata = DATA_BITS'(cfg_ff.decay_ticks);
         REG_RELEASE_TICKS: prdata = DATA_BITS'(cfg_ff.release_ticks);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level   <= RST_START_LEVEL;
         cfg_ff.peak_level    <= RST_PEAK_LEVEL;
         cfg_ff.sustain_level <= RST_SUSTAIN_LEVEL;
         cfg_ff.attack_ticks  <= RST_ATTACK_TICKS;
         cfg_ff.decay_ticks   <= RST_DECAY_TICKS;
         cfg_ff.release_ticks <= RST_RELEASE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/adsr_ctrl.sv @@
// Sequencing state machine of the ADSR envelope generator; owns the request
// handshake, the divide step counter and the result valid flag. Uses adsr_pkg.
`timescale 1ns / 1ps

module adsr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  adsr_pkg::adsr_status_type  status,
   output adsr_pkg::adsr_cmd_type     cmd
);
   import adsr_pkg::*;

   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

   adsr_state_type            state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_WAIT);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_WAIT: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.ramping && status.at_end) begin
               cmd.advance = 1'b1;
            end else if (status.ramping) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_WAIT;
            end
         end
         default: begin
            state_in = S_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WAIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/adsr_dp.sv @@
// Datapath of the ADSR envelope generator: envelope state, ramp operands,
// multiplier, radix-2 restoring divider and result payload. Uses adsr_pkg.
`timescale 1ns / 1ps

module adsr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  adsr_pkg::adsr_cmd_type        cmd,
   input  adsr_pkg::adsr_cfg_type        cfg,
   input  logic                          req_gate,
   output adsr_pkg::adsr_status_type     status,
   output logic [adsr_pkg::LEVEL_BITS-1:0] rsp_level,
   output logic [2:0]                    rsp_phase
);
   import adsr_pkg::*;

   // envelope state
   adsr_phase_type              phase_ff, phase_in;
   logic [ELAPSED_BITS-1:0]     elapsed_ff, elapsed_in;
   logic [LEVEL_BITS-1:0]       rel_start_ff, rel_start_in;
   logic [LEVEL_BITS-1:0]       last_level_ff, last_level_in;
   logic                        prev_gate_ff, prev_gate_in;

   // ramp operands and divider
   logic [LEVEL_BITS-1:0]       from_ff, from_in;
   logic                        down_ff, down_in;
   logic [LEVEL_BITS-1:0]       mag_ff, mag_in;
   logic [TICK_BITS-1:0]        e_ff, e_in;
   logic [TICK_BITS-1:0]        t_ff, t_in;
   logic [TICK_BITS-1:0]        rem_ff, rem_in;
   logic [LEVEL_BITS-1:0]       quo_ff, quo_in;

   // result payload
   logic [LEVEL_BITS-1:0]       out_level_ff, out_level_in;
   adsr_phase_type              out_phase_ff, out_phase_in;

   logic [TICK_BITS-1:0]        len;
   logic [LEVEL_BITS-1:0]       ramp_from, ramp_to;
   logic [PROD_BITS-1:0]        product;
   logic [TICK_BITS:0]          trial;
   logic                        qbit;
   logic [LEVEL_BITS-1:0]       ramp_level, level;

   // phase length and ramp end points
   always_comb begin
      case (phase_ff)
         PH_ATTACK: begin
            len = cfg.attack_ticks;  ramp_from = cfg.start_level; ramp_to = cfg.peak_level;
         end
         PH_DECAY: begin
            len = cfg.decay_ticks;   ramp_from = cfg.peak_level;  ramp_to = cfg.sustain_level;
         end
         PH_RELEASE: begin
            len = cfg.release_ticks; ramp_from = rel_start_ff;    ramp_to = '0;
         end
         default: begin
            len = '0;                ramp_from = '0;              ramp_to = '0;
         end
      endcase
   end

   assign status.ramping = (phase_ff inside {PH_ATTACK, PH_DECAY, PH_RELEASE});
   assign status.at_end  = (elapsed_ff >= {1'b0, len});

   assign product = PROD_BITS'(mag_ff) * PROD_BITS'(e_ff);
   assign trial   = {rem_ff, quo_ff[LEVEL_BITS-1]};
   assign qbit    = (trial >= {1'b0, t_ff});

   assign ramp_level = down_ff ? (from_ff - quo_ff) : (from_ff + quo_ff);

   always_comb begin
      case (phase_ff)
         PH_ATTACK, PH_DECAY, PH_RELEASE: level = ramp_level;
         PH_SUSTAIN:                      level = cfg.sustain_level;
         default:                         level = '0;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      rel_start_in  = rel_start_ff;
      last_level_in = last_level_ff;
      prev_gate_in  = prev_gate_ff;
      from_in       = from_ff;
      down_in       = down_ff;
      mag_in        = mag_ff;
      e_in          = e_ff;
      t_in          = t_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      out_level_in  = out_level_ff;
      out_phase_in  = out_phase_ff;

      if (cmd.accept) begin
         prev_gate_in = req_gate;
         if (req_gate && !prev_gate_ff) begin
            phase_in   = PH_ATTACK;
            elapsed_in = '0;
         end else if (!req_gate && prev_gate_ff &&
                      (phase_ff inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN})) begin
            phase_in     = PH_RELEASE;
            rel_start_in = last_level_ff;
            elapsed_in   = '0;
         end
      end

      if (cmd.advance) begin
         elapsed_in = '0;
         case (phase_ff)
            PH_ATTACK: phase_in = PH_DECAY;
            PH_DECAY:  phase_in = PH_SUSTAIN;
            default:   phase_in = PH_IDLE;
         endcase
      end

      if (cmd.load) begin
         from_in = ramp_from;
         down_in = (ramp_to < ramp_from);
         mag_in  = (ramp_to < ramp_from) ? (ramp_from - ramp_to) : (ramp_to - ramp_from);
         e_in    = elapsed_ff[TICK_BITS-1:0];
         t_in    = len;
      end

      // quotient is below mag, so the upper product bits start below t
      if (cmd.mul) begin
         rem_in = product[PROD_BITS-1:LEVEL_BITS];
         quo_in = product[LEVEL_BITS-1:0];
      end

      if (cmd.div_step) begin
         rem_in = qbit ? TICK_BITS'(trial - {1'b0, t_ff}) : trial[TICK_BITS-1:0];
         quo_in = {quo_ff[LEVEL_BITS-2:0], qbit};
      end

      if (cmd.commit) begin
         last_level_in = level;
         out_level_in  = level;
         out_phase_in  = phase_ff;
         if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         elapsed_ff    <= '0;
         rel_start_ff  <= '0;
         last_level_ff <= '0;
         prev_gate_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         rel_start_ff  <= rel_start_in;
         last_level_ff <= last_level_in;
         prev_gate_ff  <= prev_gate_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff      <= from_in;
      down_ff      <= down_in;
      mag_ff       <= mag_in;
      e_ff         <= e_in;
      t_ff         <= t_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      out_level_ff <= out_level_in;
      out_phase_ff <= out_phase_in;
   end

   assign rsp_level = out_level_ff;
   assign rsp_phase = out_phase_ff;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for adsr_envelope_generator: directed script, then random
// gate streams under several register settings, checked against an in-bench envelope model.
// Depends on adsr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
   import adsr_pkg::*;

   localparam int RANDOM_ITEMS = 1880;
   localparam int PHASE_COUNT  = 8;
   localparam int QUIET_LIMIT  = 20000;  // cycles without any handshake before giving up
   localparam int DRAIN_CYCLES = 40;     // idle cycles after the last response before the final check
   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = '1;
   localparam logic [TICK_BITS-1:0]  TICKS_TOP = '1;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef enum int {CFG_SHORT, CFG_EDGES, CFG_MEDIUM, CFG_LONGEST, CFG_ZERO_LEN} cfg_flavor_type;

   typedef struct {
      row_kind_type              kind;
      logic [INDEX_BITS-1:0]     index;
      logic                      gate;
      logic [DATA_BITS-1:0]      value;
      bit                        typed;
      logic [LEVEL_BITS-1:0]     level;
      adsr_phase_type            phase;
   } script_row_type;

   typedef struct {
      logic [LEVEL_BITS-1:0] level;
      adsr_phase_type        phase;
   } envelope_point_type;

   // ---------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_gate  = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]   rsp_level;
   logic [2:0]              rsp_phase;
   logic                    psel      = 1'b0;
   logic                    penable   = 1'b0;
   logic                    pwrite    = 1'b0;
   logic [ADDR_BITS-1:0]    paddr     = '0;
   logic [DATA_BITS-1:0]    pwdata    = '0;
   logic [DATA_BITS-1:0]    prdata;
   logic                    pready;

   adsr_envelope_generator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_gate  (req_gate),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_level (rsp_level),
      .rsp_phase (rsp_phase),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------
   // Envelope model: register copy and tick state, advanced once per accepted request
   // ---------------------------------------------------------------------------
   adsr_cfg_type             cfg_shadow;
   adsr_phase_type           env_phase;
   logic [ELAPSED_BITS-1:0]  env_elapsed;
   logic [LEVEL_BITS-1:0]    rel_from;
   logic [LEVEL_BITS-1:0]    env_last;
   logic                     env_gate_q;

   envelope_point_type expected_envelope [$];

   int n_sent;      // requests accepted
   int n_checked;   // responses accepted
   int errors;
   int gap_pct;     // chance that the sender holds off
   int stall_pct;   // chance that the receiver stalls
   int quiet_cycles = 0;

   // Linear ramp point: from + trunc((to - from) * e / t), split so nothing overflows.
   function automatic logic [LEVEL_BITS-1:0] ramp_value(
      input logic [LEVEL_BITS-1:0]   from_lvl,
      input logic [LEVEL_BITS-1:0]   to_lvl,
      input logic [ELAPSED_BITS-1:0] e,
      input logic [TICK_BITS-1:0]    t
   );
      longint unsigned rise;
      longint unsigned part;
      longint unsigned v;
      if (to_lvl >= from_lvl) begin
         rise = to_lvl - from_lvl;
      end else begin
         rise = from_lvl - to_lvl;
      end
      part = (rise / t) * e + ((rise % t) * e) / t;
      if (to_lvl >= from_lvl) begin
         v = from_lvl + part;
         if (v > LEVEL_TOP) v = LEVEL_TOP;
      end else begin
         v = (part > from_lvl) ? 0 : from_lvl - part;
      end
      return v[LEVEL_BITS-1:0];
   endfunction

   // One sample tick: apply the gate edge, settle finished ramps, then compute the level.
   function automatic envelope_point_type advance_envelope(input logic gate);
      envelope_point_type pt;
      pt.level = '0;
      if (gate && !env_gate_q) begin
         env_phase   = PH_ATTACK;
         env_elapsed = '0;
      end else if (!gate && env_gate_q && (env_phase == PH_ATTACK ||
                   env_phase == PH_DECAY || env_phase == PH_SUSTAIN)) begin
         env_phase   = PH_RELEASE;
         rel_from    = env_last;
         env_elapsed = '0;
      end
      env_gate_q = gate;

      if (env_phase == PH_ATTACK) begin
         if (env_elapsed >= cfg_shadow.attack_ticks) begin
            env_phase   = PH_DECAY;
            env_elapsed = '0;
         end else begin
            pt.level = ramp_value(cfg_shadow.start_level, cfg_shadow.peak_level,
                                  env_elapsed, cfg_shadow.attack_ticks);
         end
      end
      if (env_phase == PH_DECAY) begin
         if (env_elapsed >= cfg_shadow.decay_ticks) begin
            env_phase   = PH_SUSTAIN;
            env_elapsed = '0;
         end else begin
            pt.level = ramp_value(cfg_shadow.peak_level, cfg_shadow.sustain_level,
                                  env_elapsed, cfg_shadow.decay_ticks);
         end
      end
      if (env_phase == PH_SUSTAIN) pt.level = cfg_shadow.sustain_level;
      if (env_phase == PH_RELEASE) begin
         if (env_elapsed >= cfg_shadow.release_ticks) begin
            env_phase   = PH_IDLE;
            env_elapsed = '0;
         end else begin
            pt.level = ramp_value(rel_from, '0, env_elapsed, cfg_shadow.release_ticks);
         end
      end
      if (env_phase == PH_IDLE) pt.level = '0;

      // elapsed count saturates instead of wrapping
      if (env_elapsed != ELAPSED_MAX) env_elapsed = env_elapsed + 1'b1;
      env_last = pt.level;
      pt.phase = env_phase;
      return pt;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed script: reset settings, single-tick ramps, zero-length ramps, longest
   // ramps. Expected values are typed in where they follow directly from the settings.
   // ---------------------------------------------------------------------------
   script_row_type directed_script [38] = '{
      // reset settings: idle, attack start, one step, early release, retrigger
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd0, PH_IDLE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd0, PH_ATTACK},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b0, 16'd0, PH_ATTACK},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd136, PH_RELEASE},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd136, PH_RELEASE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd0, PH_ATTACK},
      // descending attack, rising decay, every ramp one tick long
      '{ROW_WRITE, REG_START_LEVEL,   1'b0, 32'd65535, 1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_PEAK_LEVEL,    1'b0, 32'd0,     1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_SUSTAIN_LEVEL, 1'b0, 32'd65535, 1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_ATTACK_TICKS,  1'b0, 32'd1,     1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_DECAY_TICKS,   1'b0, 32'd1,     1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_RELEASE_TICKS, 1'b0, 32'd1,     1'b0, 16'd0, PH_IDLE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd0,     PH_DECAY},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd65535, PH_SUSTAIN},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd65535, PH_SUSTAIN},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd65535, PH_RELEASE},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd0,     PH_IDLE},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd0,     PH_IDLE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd65535, PH_ATTACK},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd65535, PH_RELEASE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd65535, PH_ATTACK},
      // zero-length ramps are skipped within the tick
      '{ROW_WRITE, REG_ATTACK_TICKS,  1'b0, 32'd0, 1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_DECAY_TICKS,   1'b0, 32'd0, 1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_RELEASE_TICKS, 1'b0, 32'd0, 1'b0, 16'd0, PH_IDLE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd65535, PH_SUSTAIN},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd0,     PH_IDLE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd65535, PH_SUSTAIN},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd0,     PH_IDLE},
      // longest ramps
      '{ROW_WRITE, REG_START_LEVEL,   1'b0, 32'd0,        1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_PEAK_LEVEL,    1'b0, 32'd65535,    1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_SUSTAIN_LEVEL, 1'b0, 32'd0,        1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_ATTACK_TICKS,  1'b0, 32'd16777215, 1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_DECAY_TICKS,   1'b0, 32'd16777215, 1'b0, 16'd0, PH_IDLE},
      '{ROW_WRITE, REG_RELEASE_TICKS, 1'b0, 32'd16777215, 1'b0, 16'd0, PH_IDLE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd0, PH_ATTACK},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd0, PH_ATTACK},
      '{ROW_TICK,  '0, 1'b0, 32'd0, 1'b1, 16'd0, PH_RELEASE},
      '{ROW_TICK,  '0, 1'b1, 32'd0, 1'b1, 16'd0, PH_ATTACK}
   };

   cfg_flavor_type flavor_plan [PHASE_COUNT] = '{
      CFG_SHORT, CFG_EDGES, CFG_MEDIUM, CFG_LONGEST,
      CFG_SHORT, CFG_ZERO_LEN, CFG_MEDIUM, CFG_SHORT
   };

   // ---------------------------------------------------------------------------
   // Configuration port: setup cycle, access cycle, then an idle cycle
   // ---------------------------------------------------------------------------
   task automatic csr_access(input logic wr, input logic [INDEX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] wdata,
                             output logic [DATA_BITS-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write one register, mirror it in the model, and read it back.
   task automatic write_register(input logic [INDEX_BITS-1:0] idx,
                                 input logic [DATA_BITS-1:0] value);
      logic [DATA_BITS-1:0] rd;
      csr_access(1'b1, idx, value, rd);
      case (idx)
         REG_START_LEVEL:   cfg_shadow.start_level   = value[LEVEL_BITS-1:0];
         REG_PEAK_LEVEL:    cfg_shadow.peak_level    = value[LEVEL_BITS-1:0];
         REG_SUSTAIN_LEVEL: cfg_shadow.sustain_level = value[LEVEL_BITS-1:0];
         REG_ATTACK_TICKS:  cfg_shadow.attack_ticks  = value[TICK_BITS-1:0];
         REG_DECAY_TICKS:   cfg_shadow.decay_ticks   = value[TICK_BITS-1:0];
         REG_RELEASE_TICKS: cfg_shadow.release_ticks = value[TICK_BITS-1:0];
         default: ;
      endcase
      csr_access(1'b0, idx, '0, rd);
      if (rd !== value) begin
         $error("readback of register %0d: expected %0h, got %0h", idx, value, rd);
         errors++;
      end
   endtask

   // Pick a full register setting of the given flavor and write all six registers.
   task automatic program_envelope(input cfg_flavor_type flavor);
      logic [DATA_BITS-1:0] setting [6];
      bit edge_lvl;
      for (int l = 0; l < 3; l++) begin
         edge_lvl = (flavor == CFG_EDGES) || ($urandom_range(0, 9) == 0);
         if (edge_lvl) begin
            setting[l] = $urandom_range(0, 1) ? 32'(LEVEL_TOP) : 32'd0;
         end else begin
            setting[l] = $urandom_range(0, LEVEL_TOP);
         end
      end
      for (int t = 3; t < 6; t++) begin
         case (flavor)
            CFG_SHORT:    setting[t] = $urandom_range(1, 24);
            CFG_EDGES:    setting[t] = 1;
            CFG_LONGEST:  setting[t] = 32'(TICKS_TOP);
            CFG_ZERO_LEN: setting[t] = $urandom_range(0, 4);
            default: begin
               if ($urandom_range(0, 9) == 0) setting[t] = $urandom_range(1, TICKS_TOP);
               else setting[t] = $urandom_range(1, 300);
            end
         endcase
      end
      for (int i = 0; i < 6; i++) write_register(i[INDEX_BITS-1:0], setting[i]);
   endtask

   // ---------------------------------------------------------------------------
   // Request side: hold off at random, present the tick, wait for acceptance and
   // record what the response has to be.
   // ---------------------------------------------------------------------------
   task automatic send_tick(input logic gate, input bit typed,
                            input logic [LEVEL_BITS-1:0] lvl, input adsr_phase_type ph);
      envelope_point_type point;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_gate  <= gate;
      do @(posedge clock); while (req_stall);
      n_sent++;
      point = advance_envelope(gate);
      if (typed) begin
         point.level = lvl;
         point.phase = ph;
      end
      expected_envelope.push_back(point);
   endtask

   // Drop valid and hold until every outstanding request has its response.
   task automatic await_results();
      req_valid <= 1'b0;
      while (n_checked < n_sent) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random stall, and compare each accepted response in order
   // ---------------------------------------------------------------------------
   always @(posedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin
      envelope_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (expected_envelope.size() == 0) begin
            $error("response with no request outstanding: level %0d, phase %0d",
                   rsp_level, rsp_phase);
            errors++;
         end else begin
            want = expected_envelope.pop_front();
            if (rsp_level !== want.level) begin
               $error("level mismatch: expected %0d, got %0d", want.level, rsp_level);
               errors++;
            end
            if (rsp_phase !== want.phase) begin
               $error("phase mismatch: expected %0d, got %0d", want.phase, rsp_phase);
               errors++;
            end
         end
      end
   end

   // Watchdog: give up when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int   item;
      int   per_phase;
      int   hi_left;
      int   lo_left;
      int   noise_left;
      int   span;
      int   rel_span;
      logic gate;

      // model starts from the reset settings
      cfg_shadow.start_level   = RST_START_LEVEL;
      cfg_shadow.peak_level    = RST_PEAK_LEVEL;
      cfg_shadow.sustain_level = RST_SUSTAIN_LEVEL;
      cfg_shadow.attack_ticks  = RST_ATTACK_TICKS;
      cfg_shadow.decay_ticks   = RST_DECAY_TICKS;
      cfg_shadow.release_ticks = RST_RELEASE_TICKS;
      env_phase    = PH_IDLE;
      env_elapsed  = '0;
      rel_from     = '0;
      env_last     = '0;
      env_gate_q   = 1'b0;
      n_sent       = 0;
      n_checked    = 0;
      errors       = 0;
      gap_pct      = 38;
      stall_pct    = 65;
      hi_left      = 0;
      lo_left      = 0;
      noise_left   = 0;
      item         = 0;
      per_phase    = RANDOM_ITEMS / PHASE_COUNT;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // walk the directed script; registers change only with nothing in flight
      foreach (directed_script[i]) begin
         if (directed_script[i].kind == ROW_WRITE) begin
            await_results();
            write_register(directed_script[i].index, directed_script[i].value);
         end else begin
            send_tick(directed_script[i].gate, directed_script[i].typed,
                      directed_script[i].level, directed_script[i].phase);
         end
      end

      // random part: one register setting per phase, gate streams shaped as notes
      for (int p = 0; p < PHASE_COUNT; p++) begin
         await_results();
         program_envelope(flavor_plan[p]);
         span     = cfg_shadow.attack_ticks + cfg_shadow.decay_ticks;
         span     = (span > 60) ? 60 : span;
         rel_span = (cfg_shadow.release_ticks > 60) ? 60 : cfg_shadow.release_ticks;
         for (int k = 0; k < per_phase; k++) begin
            // receiver stalls most first, then sender idles most, then neither
            case (item * 3 / RANDOM_ITEMS)
               0: begin gap_pct = 38; stall_pct = 65; end
               1: begin gap_pct = 65; stall_pct = 38; end
               default: begin gap_pct = 0; stall_pct = 0; end
            endcase

            // start a new note (held key then released key) or a burst of noise
            if (noise_left == 0 && hi_left == 0 && lo_left == 0) begin
               if ($urandom_range(0, 99) < 15) begin
                  noise_left = $urandom_range(1, 6);
               end else begin
                  hi_left = $urandom_range(1, span + 12);
                  lo_left = $urandom_range(1, rel_span + 6);
               end
            end
            if (noise_left > 0) begin
               gate = 1'($urandom_range(0, 1));
               noise_left--;
            end else if (hi_left > 0) begin
               gate = 1'b1;
               hi_left--;
            end else begin
               gate = 1'b0;
               lo_left--;
            end

            send_tick(gate, 1'b0, '0, PH_IDLE);
            item++;
            // now and then let the block run completely dry mid-stream
            if ($urandom_range(0, 99) == 0) await_results();
         end
      end

      await_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_envelope.size() != 0) begin
         $error("%0d responses never arrived", expected_envelope.size());
         errors++;
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
